FILE: rtl/sorted_key_set_core_assert.svh
// assertion macros used by the checker file
`ifndef SORTED_KEY_SET_CORE_ASSERT_SVH
`define SORTED_KEY_SET_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define SKC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted key set check failed");

// next-cycle implication, masked during reset
`define SKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted key set check failed");

// next-cycle implication that also holds across reset
`define SKC_ASSERT_NEXT_ANY(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sorted key set check failed");

`endif

FILE: rtl/skc_pkg.sv
package skc_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int KEY_W            = 32;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // input beat
    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [KEY_W-1:0] key;
    } t_in_beat;

    // output beat
    typedef struct packed {
        t_status    status;
        logic [3:0] rank;
        logic [4:0] entry_count;
    } t_out_beat;

    // command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

FILE: rtl/skc_cell.sv
module skc_cell
    import skc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_cmd               i_cmd,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic                    i_left_valid,
    input  logic                    i_left_lt,
    input  logic signed [KEY_W-1:0] i_right_key,
    input  logic                    i_right_valid,
    output logic signed [KEY_W-1:0] o_key,
    output logic                    o_valid,
    output logic                    o_lt,
    output logic                    o_eq
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    r_valid;
    logic                    n_valid;

    // compare own entry with the broadcast key
    assign o_lt    = r_valid && (r_key < i_key);
    assign o_eq    = r_valid && (r_key == i_key);
    assign o_key   = r_key;
    assign o_valid = r_valid;

    // insert shifts up from the left, delete shifts down from the right
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            n_valid = r_valid | i_left_valid;
            if (!o_lt) begin
                n_key = i_left_lt ? i_key : i_left_key;
            end
        end else if (i_cmd.del) begin
            n_valid = i_right_valid;
            if (!o_lt) begin
                n_key = i_right_key;
            end
        end
    end

    // occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

FILE: rtl/sorted_key_set_core.sv
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_stall   | i_in_data  (opcode, key)
// output  | out       | o_out_valid / i_out_stall | o_out_data (status, rank, entry_count)
//
// an accepted beat waits in the pending register and is executed by the whole row
// of cells at once (compare, rank encode, shift) once the output register is free,
// so one beat per cycle is sustained while the output is not stalled
// the output register holds a result while i_out_stall is high; the input
// stalls only while a pending beat cannot execute into a busy output register
// reset clears the occupancy bits, count and handshake state
module sorted_key_set_core
    import skc_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);

    logic                    r_pend;
    logic [1:0]              r_op;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    t_out_beat               r_out;
    t_out_beat               n_out;

    logic                    w_exec;
    logic                    w_accept;
    logic                    w_present;
    logic                    w_full;
    t_cell_cmd               w_cmd;
    t_status                 w_status;
    logic [PW-1:0]           w_pos;
    logic [PW+3:0]           w_rank_ext;
    logic [CW+4:0]           w_cnt_ext;

    logic signed [KEY_W-1:0] w_key   [CAPACITY];
    logic [CAPACITY-1:0]     w_valid;
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_bound;

    // handshake
    assign w_exec     = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !w_exec;
    assign w_accept   = i_in_valid && !o_in_stall;

    // pending beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_accept) begin
            r_pend <= 1'b1;
        end else if (w_exec) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in_data.opcode;
            r_key <= i_in_data.key;
        end
    end

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] w_lkey;
        logic signed [KEY_W-1:0] w_rkey;
        logic                    w_lvalid;
        logic                    w_llt;
        logic                    w_rvalid;

        if (g == 0) begin : g_first
            assign w_lkey   = '0;
            assign w_lvalid = 1'b1;
            assign w_llt    = 1'b1;
            assign w_bound[g] = !w_lt[g];
        end else begin : g_mid
            assign w_lkey   = w_key[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_llt    = w_lt[g-1];
            assign w_bound[g] = !w_lt[g] && w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rkey   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_inner
            assign w_rkey   = w_key[g+1];
            assign w_rvalid = w_valid[g+1];
        end

        skc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_key         (r_key),
            .i_left_key    (w_lkey),
            .i_left_valid  (w_lvalid),
            .i_left_lt     (w_llt),
            .i_right_key   (w_rkey),
            .i_right_valid (w_rvalid),
            .o_key         (w_key[g]),
            .o_valid       (w_valid[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // insertion point: index of the edge in the less-than thermometer
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_bound[i]) begin
                w_pos = w_pos | PW'(i);
            end
        end
    end

    assign w_present = |w_eq;
    assign w_full    = (r_count == CW'(CAPACITY));

    // decide the operation
    always_comb begin
        case (r_op)
            OP_INSERT: w_status = w_present ? ST_DUP : (w_full ? ST_FULL : ST_OK);
            OP_DELETE: w_status = w_present ? ST_OK : ST_MISS;
            OP_SEARCH: w_status = w_present ? ST_OK : ST_MISS;
            default:   w_status = ST_MISS;
        endcase
    end

    assign w_cmd.ins = w_exec && (r_op == OP_INSERT) && (w_status == ST_OK);
    assign w_cmd.del = w_exec && (r_op == OP_DELETE) && (w_status == ST_OK);

    // entry count
    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result beat
    assign w_rank_ext = (PW+4)'(w_pos);
    assign w_cnt_ext  = (CW+5)'(n_count);

    always_comb begin
        n_out.status      = w_status;
        n_out.rank        = (w_status == ST_OK) ? w_rank_ext[3:0] : 4'd0;
        n_out.entry_count = w_cnt_ext[4:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/skc_checker.sv
`include "sorted_key_set_core_assert.svh"

module skc_checker
    import skc_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    localparam logic [4:0] FULL_CNT = 5'(CAPACITY);

    // a stalled result beat holds
    `SKC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // reset leaves both channels quiet and ready
    `SKC_ASSERT_NEXT_ANY(a_reset_idle, !i_rst_n, !o_out_valid && !o_in_stall)

    // a failed operation reports rank zero
    `SKC_ASSERT_NOW(a_rank_zero, o_out_valid && (o_out_data.status != ST_OK), o_out_data.rank == 4'd0)

    // full is only reported at capacity
    `SKC_ASSERT_NOW(a_full_count, o_out_valid && (o_out_data.status == ST_FULL), o_out_data.entry_count == FULL_CNT)

endmodule

bind sorted_key_set_core skc_checker #(.CAPACITY(CAPACITY)) u_skc_checker (.*);

FILE: verif/tb.sv
module tb;
    import skc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP            = DEFAULT_CAPACITY;
    localparam int POOL_N         = 24;
    localparam int PHASE_N        = 6;
    localparam int PHASE_ITEMS    = 75;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SHOW_LIMIT     = 10;

    // opcode outside the enum: no operation
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // one directed row: beat plus optional hand-written result
    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
        logic                    fixed;
        t_status                 st;
        logic [3:0]              rank;
        logic [4:0]              cnt;
    } t_dir_row;

    localparam int DIR_N = 25;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // empty store after reset
        '{OP_SEARCH, 32'sd0,            1'b1, ST_MISS, 4'd0,  5'd0},
        '{OP_DELETE, 32'sd7,            1'b1, ST_MISS, 4'd0,  5'd0},
        '{OP_NOP,    32'sd0,            1'b1, ST_MISS, 4'd0,  5'd0},
        // extremes of the key range
        '{OP_INSERT, KEY_MIN,           1'b1, ST_OK,   4'd0,  5'd1},
        '{OP_INSERT, KEY_MAX,           1'b1, ST_OK,   4'd1,  5'd2},
        // fill up to capacity
        '{OP_INSERT, 32'sd0,            1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, -32'sd1,           1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sd1,            1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sd100,          1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, -32'sd100,         1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sh4000_0000,    1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, -32'sd5,           1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sd7,            1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sd3,            1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sh8000_0001,    1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sh7fff_fffe,    1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sd12345,        1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, -32'sd12345,       1'b0, ST_OK,   4'd0,  5'd0},
        '{OP_INSERT, 32'sd9,            1'b0, ST_OK,   4'd0,  5'd0},
        // full store, duplicate wins over full
        '{OP_INSERT, 32'sd5,            1'b1, ST_FULL, 4'd0,  5'd16},
        '{OP_INSERT, KEY_MAX,           1'b1, ST_DUP,  4'd0,  5'd16},
        '{OP_SEARCH, KEY_MAX,           1'b1, ST_OK,   4'd15, 5'd16},
        // delete present then absent, no operation
        '{OP_DELETE, KEY_MIN,           1'b1, ST_OK,   4'd0,  5'd15},
        '{OP_DELETE, KEY_MIN,           1'b1, ST_MISS, 4'd0,  5'd15},
        '{OP_NOP,    KEY_MAX,           1'b1, ST_MISS, 4'd0,  5'd15}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;

    // model of the store and expected results
    logic signed [KEY_W-1:0] held_keys [$];
    t_out_beat               result_q [$];
    logic signed [KEY_W-1:0] key_pool [POOL_N];
    int                      fail_cnt = 0;
    bit                      in_burst = 1'b0;
    bit                      out_burst = 1'b0;

    sorted_key_set_core #(
        .CAPACITY (CAP)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // apply one operation to the modeled store and return its result
    function automatic t_out_beat apply_op(input logic [1:0] op,
                                           input logic signed [KEY_W-1:0] key);
        t_out_beat res;
        int        pos;
        bit        present;
        pos = 0;
        foreach (held_keys[i]) begin
            if (held_keys[i] < key) pos++;
        end
        present = (pos < held_keys.size()) && (held_keys[pos] == key);
        res.status = ST_MISS;
        res.rank   = '0;
        case (op)
            OP_INSERT: begin
                if (present) begin
                    res.status = ST_DUP;
                end else if (held_keys.size() >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    held_keys.insert(pos, key);
                    res.status = ST_OK;
                    res.rank   = pos[3:0];
                end
            end
            OP_DELETE: begin
                if (present) begin
                    held_keys.delete(pos);
                    res.status = ST_OK;
                    res.rank   = pos[3:0];
                end
            end
            OP_SEARCH: begin
                if (present) begin
                    res.status = ST_OK;
                    res.rank   = pos[3:0];
                end
            end
            default: ;
        endcase
        res.entry_count = 5'(held_keys.size());
        return res;
    endfunction

    // key for a random beat: held keys, the phase pool, or anything
    function automatic logic signed [KEY_W-1:0] pick_key(input bit prefer_held);
        if (prefer_held && held_keys.size() != 0 && $urandom_range(0, 1) == 1)
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom;
    endfunction

    function automatic void report_mismatch(input string what, input t_out_beat exp_res,
                                            input t_out_beat got);
        fail_cnt++;
        if (fail_cnt <= SHOW_LIMIT)
            $display("tb: %s at %0t: exp st=%0d rank=%0d cnt=%0d got st=%0d rank=%0d cnt=%0d",
                     what, $realtime, exp_res.status, exp_res.rank, exp_res.entry_count,
                     got.status, got.rank, got.entry_count);
    endfunction

    // drive one input beat and record its expected result at accept
    task automatic send_beat(input t_in_beat beat, input bit fixed, input t_out_beat fixed_res);
        int        gap;
        bit        acc;
        t_out_beat res;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do begin
            @(negedge clk);
            acc = (in_stall === 1'b0);
            @(posedge clk);
        end while (!acc);
        res = apply_op(beat.opcode, beat.key);
        result_q.push_back(fixed ? fixed_res : res);
    endtask

    // stimulus and end of run
    initial begin
        t_in_beat  beat;
        t_out_beat fixed_res;
        int        ins_pct;
        int        del_pct;
        int        r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++) begin
            beat.opcode           = DIR_ROWS[i].op;
            beat.key              = DIR_ROWS[i].key;
            fixed_res.status      = DIR_ROWS[i].st;
            fixed_res.rank        = DIR_ROWS[i].rank;
            fixed_res.entry_count = DIR_ROWS[i].cnt;
            send_beat(beat, DIR_ROWS[i].fixed, fixed_res);
        end

        // random phases: fill, churn, drain
        for (int ph = 0; ph < PHASE_N; ph++) begin
            key_pool[0] = KEY_MIN;
            key_pool[1] = KEY_MAX;
            for (int k = 2; k < POOL_N; k++)
                key_pool[k] = (k % 2 == 0) ? $urandom : $urandom_range(0, 40) - 20;
            case (ph)
                0, 3:    begin ins_pct = 65; del_pct = 10; end
                2, 5:    begin ins_pct = 15; del_pct = 60; end
                default: begin ins_pct = 35; del_pct = 30; end
            endcase
            in_burst = (ph == 2 || ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    beat.opcode = OP_INSERT;
                else if (r < ins_pct + del_pct)
                    beat.opcode = OP_DELETE;
                else if (r < 96)
                    beat.opcode = OP_SEARCH;
                else
                    beat.opcode = OP_NOP;
                beat.key = pick_key(beat.opcode != OP_INSERT);
                send_beat(beat, 1'b0, '0);
            end
            // hold off until the block has answered everything
            if (ph == 1 || ph == 3) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (result_q.size() != 0) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        // drain
        while (result_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // reset pulse is driven above; output side with random stalls
    initial begin
        t_out_beat got;
        t_out_beat exp_res;
        int        hold;
        bit        acc;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
            hold = out_burst ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                acc = (out_valid === 1'b1);
                got = out_data;
                @(posedge clk);
            end while (!acc);
            // compare the result beat with the oldest expectation
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                exp_res = result_q.pop_front();
                if (got.status !== exp_res.status || got.rank !== exp_res.rank ||
                    got.entry_count !== exp_res.entry_count)
                    report_mismatch("mismatch", exp_res, got);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
